// ===== hdl/olst_pkg.sv =====
// Package for the ordered list store: field widths, default sizes, codes and
// the control struct that the controller broadcasts to the row of cells.
// No dependencies.
`timescale 1ns / 1ps

package olst_pkg;

   // Default sizes of the list.
   localparam int DEF_CAPACITY   = 64;
   localparam int DEF_WORD_WIDTH = 32;

   // Fixed widths of the beat fields.
   localparam int ACTION_WIDTH = 3;
   localparam int POS_WIDTH    = 7;
   localparam int VALUE_WIDTH  = 32;
   localparam int STATUS_WIDTH = 2;
   localparam int COUNT_WIDTH  = 7;

   // Request actions.
   typedef enum logic [ACTION_WIDTH-1:0] {
      ACT_APPEND = 3'd0,
      ACT_INSERT = 3'd1,
      ACT_POP    = 3'd2,
      ACT_DELETE = 3'd3,
      ACT_SEARCH = 3'd4,
      ACT_READ   = 3'd5
   } action_type;

   // Response status codes.
   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_DONE  = 2'd0,
      ST_ERROR = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // What every cell does with its word in the current cycle.
   typedef enum logic [1:0] {
      SH_HOLD   = 2'd0,
      SH_APPEND = 2'd1,
      SH_INSERT = 2'd2,
      SH_DELETE = 2'd3
   } shift_kind_type;

   // Controller states.
   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_EXEC = 2'd1,
      S_SCAN = 2'd2,
      S_DONE = 2'd3
   } state_type;

   // Broadcast from the controller to all cells.
   typedef struct packed {
      shift_kind_type kind;
      logic           scan_read;
   } cell_ctl_type;

endpackage

// ===== hdl/ordered_list_store.sv =====
// Top level of the ordered list store: the controller and a row of cells.
// Depends on olst_pkg, olst_ctrl and olst_cell.
`timescale 1ns / 1ps
//
//   Channel   Direction  Handshake              Beat contents
//   req_      in         req_valid / req_stall  action, position, value
//   rsp_      out        rsp_valid / rsp_stall  status, read_value, found, entry_count
//
// Append, insert, remove last, delete and undefined actions go from accept through
// the execute and done states to idle; the shift happens in all cells together.
// Search and read also pass through the scan state, while the scan result walks the
// row of cells, one cell per cycle. Reset empties the list at once.
// A result waiting behind rsp_stall sits in the output register while the next
// request is taken and worked on.

module ordered_list_store #(
   parameter int CAPACITY   = olst_pkg::DEF_CAPACITY,
   parameter int WORD_WIDTH = olst_pkg::DEF_WORD_WIDTH
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [olst_pkg::ACTION_WIDTH-1:0]       req_action,
   input  logic [olst_pkg::POS_WIDTH-1:0]          req_position,
   input  logic signed [olst_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [olst_pkg::STATUS_WIDTH-1:0]       rsp_status,
   output logic signed [olst_pkg::VALUE_WIDTH-1:0] rsp_read_value,
   output logic                                    rsp_found,
   output logic [olst_pkg::COUNT_WIDTH-1:0]        rsp_entry_count
);

   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > olst_pkg::POS_WIDTH) ? CW : olst_pkg::POS_WIDTH;

   olst_pkg::cell_ctl_type cell_ctl;
   logic [CMPW-1:0]        op_pos;
   logic [CMPW-1:0]        op_count;
   logic [WORD_WIDTH-1:0]  op_key;
   logic [WORD_WIDTH-1:0]  word [CAPACITY];
   logic                   carry_hit [CAPACITY+1];
   logic [WORD_WIDTH-1:0]  carry_data [CAPACITY+1];

   // Controller.
   olst_ctrl #(
      .CAPACITY   (CAPACITY),
      .WORD_WIDTH (WORD_WIDTH),
      .CMPW       (CMPW)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value),
      .rsp_found       (rsp_found),
      .rsp_entry_count (rsp_entry_count),
      .cell_ctl        (cell_ctl),
      .op_pos          (op_pos),
      .op_count        (op_count),
      .op_key          (op_key),
      .scan_hit        (carry_hit[CAPACITY]),
      .scan_data       (carry_data[CAPACITY])
   );

   // The scan chain starts empty at the head of the row.
   assign carry_hit[0]  = 1'b0;
   assign carry_data[0] = '0;

   // Row of cells; the ends use their own word as the missing neighbor.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [WORD_WIDTH-1:0] left_word;
      logic [WORD_WIDTH-1:0] right_word;

      if (i == 0) begin : g_head
         assign left_word = word[i];
      end else begin : g_body
         assign left_word = word[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_word = word[i];
      end else begin : g_inner
         assign right_word = word[i+1];
      end

      olst_cell #(
         .WORD_WIDTH (WORD_WIDTH),
         .CMPW       (CMPW),
         .INDEX      (i)
      ) u_cell (
         .clock          (clock),
         .ctl            (cell_ctl),
         .op_pos         (op_pos),
         .op_count       (op_count),
         .op_key         (op_key),
         .left_word      (left_word),
         .right_word     (right_word),
         .word           (word[i]),
         .carry_in_hit   (carry_hit[i]),
         .carry_in_data  (carry_data[i]),
         .carry_out_hit  (carry_hit[i+1]),
         .carry_out_data (carry_data[i+1])
      );
   end

endmodule

// ===== hdl/olst_cell.sv =====
// One cell of the list: holds one entry, shifts it to and from its neighbors,
// and passes the scan result down the row. Depends on olst_pkg.
`timescale 1ns / 1ps

module olst_cell #(
   parameter int WORD_WIDTH = olst_pkg::DEF_WORD_WIDTH,
   parameter int CMPW       = olst_pkg::POS_WIDTH,
   parameter int INDEX      = 0
) (
   input  logic                  clock,
   input  olst_pkg::cell_ctl_type ctl,
   input  logic [CMPW-1:0]       op_pos,
   input  logic [CMPW-1:0]       op_count,
   input  logic [WORD_WIDTH-1:0] op_key,
   input  logic [WORD_WIDTH-1:0] left_word,
   input  logic [WORD_WIDTH-1:0] right_word,
   output logic [WORD_WIDTH-1:0] word,
   input  logic                  carry_in_hit,
   input  logic [WORD_WIDTH-1:0] carry_in_data,
   output logic                  carry_out_hit,
   output logic [WORD_WIDTH-1:0] carry_out_data
);

   localparam logic [CMPW-1:0] IDX = CMPW'(INDEX);

   logic [WORD_WIDTH-1:0] word_ff;
   logic [WORD_WIDTH-1:0] word_in;
   logic                  hit_ff;
   logic                  hit_in;
   logic [WORD_WIDTH-1:0] data_ff;
   logic [WORD_WIDTH-1:0] data_in;
   logic                  match;

   // Next entry value: write, take from the left neighbor, or from the right.
   always_comb begin
      word_in = word_ff;
      case (ctl.kind)
         olst_pkg::SH_APPEND: begin
            if (IDX == op_count) begin
               word_in = op_key;
            end
         end
         olst_pkg::SH_INSERT: begin
            if (IDX == op_pos) begin
               word_in = op_key;
            end else if (IDX > op_pos) begin
               word_in = left_word;
            end
         end
         olst_pkg::SH_DELETE: begin
            if (IDX >= op_pos) begin
               word_in = right_word;
            end
         end
         default: begin
            word_in = word_ff;
         end
      endcase
   end

   // Scan step: the first matching cell puts its entry on the chain.
   always_comb begin
      match = (IDX < op_count) && (ctl.scan_read ? (IDX == op_pos) : (word_ff == op_key));
      if (carry_in_hit) begin
         hit_in  = 1'b1;
         data_in = carry_in_data;
      end else begin
         hit_in  = match;
         data_in = match ? word_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      hit_ff  <= hit_in;
      data_ff <= data_in;
   end

   assign word           = word_ff;
   assign carry_out_hit  = hit_ff;
   assign carry_out_data = data_ff;

endmodule

// ===== hdl/olst_ctrl.sv =====
// Controller of the list: request and response handshakes, entry count,
// status checks and the broadcast to the cells. Depends on olst_pkg.
`timescale 1ns / 1ps

module olst_ctrl #(
   parameter int CAPACITY   = olst_pkg::DEF_CAPACITY,
   parameter int WORD_WIDTH = olst_pkg::DEF_WORD_WIDTH,
   parameter int CMPW       = olst_pkg::POS_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [olst_pkg::ACTION_WIDTH-1:0]   req_action,
   input  logic [olst_pkg::POS_WIDTH-1:0]      req_position,
   input  logic signed [olst_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [olst_pkg::STATUS_WIDTH-1:0]   rsp_status,
   output logic signed [olst_pkg::VALUE_WIDTH-1:0] rsp_read_value,
   output logic                                rsp_found,
   output logic [olst_pkg::COUNT_WIDTH-1:0]    rsp_entry_count,
   output olst_pkg::cell_ctl_type              cell_ctl,
   output logic [CMPW-1:0]                     op_pos,
   output logic [CMPW-1:0]                     op_count,
   output logic [WORD_WIDTH-1:0]               op_key,
   input  logic                                scan_hit,
   input  logic [WORD_WIDTH-1:0]               scan_data
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CMPW-1:0] CAP_CMP   = CMPW'(CAPACITY);
   localparam logic [CW-1:0]   SCAN_LAST = CW'(CAPACITY);
   localparam logic [CW-1:0]   CNT_ONE   = CW'(1);

   olst_pkg::state_type  state_ff, state_in;
   logic [olst_pkg::ACTION_WIDTH-1:0] action_ff, action_in;
   logic [CMPW-1:0]       pos_ff, pos_in;
   logic [WORD_WIDTH-1:0] key_ff, key_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         scan_cnt_ff, scan_cnt_in;
   olst_pkg::status_type  pend_status_ff, pend_status_in;
   logic [olst_pkg::VALUE_WIDTH-1:0] pend_read_ff, pend_read_in;
   logic                  pend_found_ff, pend_found_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   olst_pkg::status_type  rsp_status_ff, rsp_status_in;
   logic [olst_pkg::VALUE_WIDTH-1:0] rsp_read_ff, rsp_read_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic [olst_pkg::COUNT_WIDTH-1:0] rsp_count_ff, rsp_count_in;

   logic                  accept;
   logic                  rsp_free;
   logic                  is_scan_op;
   logic                  is_read;
   logic                  is_search;
   logic [CMPW-1:0]       count_cmp;
   logic [2*olst_pkg::VALUE_WIDTH-1:0] value_ext;
   logic [WORD_WIDTH+olst_pkg::VALUE_WIDTH-1:0] data_ext;
   olst_pkg::status_type  exec_status;
   olst_pkg::shift_kind_type exec_kind;

   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign is_read   = (action_ff == olst_pkg::ACT_READ);
   assign is_search = (action_ff == olst_pkg::ACT_SEARCH);
   assign is_scan_op = is_read || is_search;
   assign count_cmp = CMPW'(count_ff);

   // Request word reduced to the entry width; entries sign-extended back out.
   assign value_ext = {{olst_pkg::VALUE_WIDTH{req_value[olst_pkg::VALUE_WIDTH-1]}}, req_value};
   assign data_ext  = {{olst_pkg::VALUE_WIDTH{scan_data[WORD_WIDTH-1]}}, scan_data};

   // Status checks and shift command for each request action.
   always_comb begin
      exec_status = olst_pkg::ST_DONE;
      exec_kind   = olst_pkg::SH_HOLD;
      unique case (olst_pkg::action_type'(action_ff))
         olst_pkg::ACT_APPEND: begin
            if (count_cmp >= CAP_CMP) begin
               exec_status = olst_pkg::ST_FULL;
            end else begin
               exec_kind = olst_pkg::SH_APPEND;
            end
         end
         olst_pkg::ACT_INSERT: begin
            if (pos_ff > count_cmp) begin
               exec_status = olst_pkg::ST_ERROR;
            end else if (count_cmp >= CAP_CMP) begin
               exec_status = olst_pkg::ST_FULL;
            end else begin
               exec_kind = olst_pkg::SH_INSERT;
            end
         end
         olst_pkg::ACT_POP: begin
            if (count_ff == '0) begin
               exec_status = olst_pkg::ST_ERROR;
            end
         end
         olst_pkg::ACT_DELETE: begin
            if (pos_ff >= count_cmp) begin
               exec_status = olst_pkg::ST_ERROR;
            end else begin
               exec_kind = olst_pkg::SH_DELETE;
            end
         end
         olst_pkg::ACT_SEARCH, olst_pkg::ACT_READ: begin
            exec_status = olst_pkg::ST_DONE;
         end
         default: begin
            exec_status = olst_pkg::ST_ERROR;
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         olst_pkg::S_IDLE: begin
            if (accept) begin
               state_in = olst_pkg::S_EXEC;
            end
         end
         olst_pkg::S_EXEC: begin
            state_in = is_scan_op ? olst_pkg::S_SCAN : olst_pkg::S_DONE;
         end
         olst_pkg::S_SCAN: begin
            if (scan_cnt_ff == SCAN_LAST) begin
               state_in = olst_pkg::S_DONE;
            end
         end
         olst_pkg::S_DONE: begin
            if (rsp_free) begin
               state_in = olst_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = olst_pkg::S_IDLE;
         end
      endcase
   end

   // Outputs and register updates for each state.
   always_comb begin
      req_stall      = (state_ff != olst_pkg::S_IDLE);
      cell_ctl.kind  = olst_pkg::SH_HOLD;
      cell_ctl.scan_read = is_read;
      action_in      = action_ff;
      pos_in         = pos_ff;
      key_in         = key_ff;
      count_in       = count_ff;
      scan_cnt_in    = scan_cnt_ff;
      pend_status_in = pend_status_ff;
      pend_read_in   = pend_read_ff;
      pend_found_in  = pend_found_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_read_in    = rsp_read_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_count_in   = rsp_count_ff;
      unique case (state_ff)
         olst_pkg::S_IDLE: begin
            if (accept) begin
               action_in = req_action;
               pos_in    = CMPW'(req_position);
               key_in    = value_ext[WORD_WIDTH-1:0];
            end
         end
         olst_pkg::S_EXEC: begin
            cell_ctl.kind  = exec_kind;
            scan_cnt_in    = CNT_ONE;
            pend_status_in = exec_status;
            pend_read_in   = '0;
            pend_found_in  = 1'b0;
            if (exec_status == olst_pkg::ST_DONE) begin
               if (exec_kind == olst_pkg::SH_APPEND || exec_kind == olst_pkg::SH_INSERT) begin
                  count_in = count_ff + CNT_ONE;
               end else if (exec_kind == olst_pkg::SH_DELETE ||
                            action_ff == olst_pkg::ACT_POP) begin
                  count_in = count_ff - CNT_ONE;
               end
            end
         end
         olst_pkg::S_SCAN: begin
            scan_cnt_in = scan_cnt_ff + CNT_ONE;
            if (scan_cnt_ff == SCAN_LAST) begin
               pend_status_in = (is_read && !scan_hit) ? olst_pkg::ST_ERROR
                                                       : olst_pkg::ST_DONE;
               pend_read_in   = is_read ? data_ext[olst_pkg::VALUE_WIDTH-1:0] : '0;
               pend_found_in  = is_search && scan_hit;
            end
         end
         olst_pkg::S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_read_in   = pend_read_ff;
               rsp_found_in  = pend_found_ff;
               rsp_count_in  = olst_pkg::COUNT_WIDTH'(count_ff);
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= olst_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      action_ff      <= action_in;
      pos_ff         <= pos_in;
      key_ff         <= key_in;
      scan_cnt_ff    <= scan_cnt_in;
      pend_status_ff <= pend_status_in;
      pend_read_ff   <= pend_read_in;
      pend_found_ff  <= pend_found_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_read_ff    <= rsp_read_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign op_pos          = pos_ff;
   assign op_count        = count_cmp;
   assign op_key          = key_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = rsp_read_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the ordered list store: directed and random request beats
// against an in-bench list predictor, with random idling on both channels.
// Depends on olst_pkg and ordered_list_store.
`timescale 1ns / 1ps

module tb_top;

   localparam int CAPACITY       = olst_pkg::DEF_CAPACITY;
   localparam int RANDOM_ITEMS   = 530;
   localparam int QUIET_LIMIT    = 4000;
   localparam int DRAIN_CYCLES   = 2 * (CAPACITY + 3);
   localparam logic [olst_pkg::ACTION_WIDTH-1:0] ACT_UNDEF_LO = 3'd6;
   localparam logic [olst_pkg::ACTION_WIDTH-1:0] ACT_UNDEF_HI = 3'd7;
   localparam logic signed [olst_pkg::VALUE_WIDTH-1:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [olst_pkg::VALUE_WIDTH-1:0] WORD_MAX = 32'sh7FFF_FFFF;

   typedef struct packed {
      logic [olst_pkg::ACTION_WIDTH-1:0]       action;
      logic [olst_pkg::POS_WIDTH-1:0]          position;
      logic signed [olst_pkg::VALUE_WIDTH-1:0] value;
   } req_beat_type;

   typedef struct packed {
      olst_pkg::status_type                    status;
      logic signed [olst_pkg::VALUE_WIDTH-1:0] read_value;
      logic                                    found;
      logic [olst_pkg::COUNT_WIDTH-1:0]        entry_count;
   } rsp_beat_type;

   // A directed row carries its own result only where it is plain to see.
   typedef struct {
      req_beat_type beat;
      bit           has_result;
      rsp_beat_type result;
   } script_row_type;

   typedef enum {MIX_GROW, MIX_BALANCED, MIX_SHRINK} mix_kind_type;
   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [olst_pkg::ACTION_WIDTH-1:0] req_action = '0;
   logic [olst_pkg::POS_WIDTH-1:0] req_position = '0;
   logic signed [olst_pkg::VALUE_WIDTH-1:0] req_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [olst_pkg::STATUS_WIDTH-1:0] rsp_status;
   logic signed [olst_pkg::VALUE_WIDTH-1:0] rsp_read_value;
   logic rsp_found;
   logic [olst_pkg::COUNT_WIDTH-1:0] rsp_entry_count;

   // Predicted contents of the list.
   logic signed [olst_pkg::VALUE_WIDTH-1:0] list_words [CAPACITY];
   int list_count = 0;

   script_row_type script [$];
   rsp_beat_type   pending_results [$];
   int             fail_count = 0;

   ordered_list_store i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value),
      .rsp_found       (rsp_found),
      .rsp_entry_count (rsp_entry_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Applies one request to the predicted list and returns the result it gives.
   task automatic apply_list_request(input req_beat_type rq, output rsp_beat_type rs);
      int i;
      int pos;
      pos = int'(rq.position);
      rs.status = olst_pkg::ST_DONE;
      rs.read_value = '0;
      rs.found = 1'b0;
      case (rq.action)
         olst_pkg::ACT_APPEND: begin
            if (list_count >= CAPACITY) begin
               rs.status = olst_pkg::ST_FULL;
            end else begin
               list_words[list_count] = rq.value;
               list_count++;
            end
         end
         olst_pkg::ACT_INSERT: begin
            // The position check comes before the full check.
            if (pos > list_count) begin
               rs.status = olst_pkg::ST_ERROR;
            end else if (list_count >= CAPACITY) begin
               rs.status = olst_pkg::ST_FULL;
            end else begin
               for (i = list_count; i > pos; i--) list_words[i] = list_words[i-1];
               list_words[pos] = rq.value;
               list_count++;
            end
         end
         olst_pkg::ACT_POP: begin
            if (list_count == 0) rs.status = olst_pkg::ST_ERROR;
            else list_count--;
         end
         olst_pkg::ACT_DELETE: begin
            if (pos >= list_count) begin
               rs.status = olst_pkg::ST_ERROR;
            end else begin
               list_count--;
               for (i = pos; i < list_count; i++) list_words[i] = list_words[i+1];
            end
         end
         olst_pkg::ACT_SEARCH: begin
            for (i = 0; i < list_count; i++) begin
               if (list_words[i] == rq.value) rs.found = 1'b1;
            end
         end
         olst_pkg::ACT_READ: begin
            if (pos >= list_count) rs.status = olst_pkg::ST_ERROR;
            else rs.read_value = list_words[pos];
         end
         default: begin
            rs.status = olst_pkg::ST_ERROR;
         end
      endcase
      rs.entry_count = list_count[olst_pkg::COUNT_WIDTH-1:0];
   endtask

   function automatic script_row_type make_row(
         input logic [olst_pkg::ACTION_WIDTH-1:0]       action,
         input int                                      position,
         input logic signed [olst_pkg::VALUE_WIDTH-1:0] value,
         input int                                      has_result,
         input olst_pkg::status_type                    status,
         input logic signed [olst_pkg::VALUE_WIDTH-1:0] read_value,
         input int                                      found,
         input int                                      entry_count);
      script_row_type row;
      row.beat.action = action;
      row.beat.position = position[olst_pkg::POS_WIDTH-1:0];
      row.beat.value = value;
      row.has_result = (has_result != 0);
      row.result.status = status;
      row.result.read_value = read_value;
      row.result.found = (found != 0);
      row.result.entry_count = entry_count[olst_pkg::COUNT_WIDTH-1:0];
      return row;
   endfunction

   // Directed beats: empty-list errors, extremes, insert at the end, bad indexes and
   // the undefined actions.
   initial begin
      script.push_back(make_row(olst_pkg::ACT_READ,    0, 0, 1, olst_pkg::ST_ERROR, 0, 0, 0));
      script.push_back(make_row(olst_pkg::ACT_POP,     0, 0, 1, olst_pkg::ST_ERROR, 0, 0, 0));
      script.push_back(make_row(olst_pkg::ACT_DELETE,  0, 0, 1, olst_pkg::ST_ERROR, 0, 0, 0));
      script.push_back(make_row(olst_pkg::ACT_SEARCH,  0, 0, 1, olst_pkg::ST_DONE,  0, 0, 0));
      script.push_back(make_row(olst_pkg::ACT_INSERT,  1, 5, 1, olst_pkg::ST_ERROR, 0, 0, 0));
      script.push_back(make_row(olst_pkg::ACT_INSERT,  0, WORD_MIN, 1,
                                olst_pkg::ST_DONE, 0, 0, 1));
      script.push_back(make_row(olst_pkg::ACT_APPEND, 127, WORD_MAX, 1,
                                olst_pkg::ST_DONE, 0, 0, 2));
      script.push_back(make_row(olst_pkg::ACT_READ,    0, 0, 1,
                                olst_pkg::ST_DONE, WORD_MIN, 0, 2));
      script.push_back(make_row(olst_pkg::ACT_READ,    1, -1, 1,
                                olst_pkg::ST_DONE, WORD_MAX, 0, 2));
      script.push_back(make_row(olst_pkg::ACT_READ,    2, 0, 1, olst_pkg::ST_ERROR, 0, 0, 2));
      script.push_back(make_row(olst_pkg::ACT_READ,  127, 0, 1, olst_pkg::ST_ERROR, 0, 0, 2));
      script.push_back(make_row(olst_pkg::ACT_SEARCH, 64, WORD_MAX, 1,
                                olst_pkg::ST_DONE, 0, 1, 2));
      script.push_back(make_row(olst_pkg::ACT_SEARCH,  0, -1, 1, olst_pkg::ST_DONE, 0, 0, 2));
      script.push_back(make_row(olst_pkg::ACT_INSERT,  2, -1, 0, olst_pkg::ST_DONE, 0, 0, 0));
      script.push_back(make_row(olst_pkg::ACT_INSERT,  1, 0,  0, olst_pkg::ST_DONE, 0, 0, 0));
      script.push_back(make_row(olst_pkg::ACT_INSERT,  4, 7,  0, olst_pkg::ST_DONE, 0, 0, 0));
      script.push_back(make_row(olst_pkg::ACT_INSERT,  6, 1,  0, olst_pkg::ST_DONE, 0, 0, 0));
      script.push_back(make_row(olst_pkg::ACT_DELETE,  0, 0,  0, olst_pkg::ST_DONE, 0, 0, 0));
      script.push_back(make_row(olst_pkg::ACT_DELETE,  4, 0,  0, olst_pkg::ST_DONE, 0, 0, 0));
      script.push_back(make_row(olst_pkg::ACT_DELETE,  1, 0,  0, olst_pkg::ST_DONE, 0, 0, 0));
      script.push_back(make_row(ACT_UNDEF_LO, 3, -1, 0, olst_pkg::ST_DONE, 0, 0, 0));
      script.push_back(make_row(ACT_UNDEF_HI, 127, WORD_MIN, 0, olst_pkg::ST_DONE, 0, 0, 0));
      script.push_back(make_row(olst_pkg::ACT_SEARCH,  0, 0,  0, olst_pkg::ST_DONE, 0, 0, 0));
      script.push_back(make_row(olst_pkg::ACT_POP,     0, 0,  0, olst_pkg::ST_DONE, 0, 0, 0));
      script.push_back(make_row(olst_pkg::ACT_READ,    0, 0,  0, olst_pkg::ST_DONE, 0, 0, 0));
   end

   // Random request generation. Phases lean toward growing or shrinking the list so
   // that it reaches both full and empty several times.
   mix_kind_type mix_mode = MIX_GROW;
   int mix_left = 120;

   function automatic logic [olst_pkg::ACTION_WIDTH-1:0] pick_action(input mix_kind_type mode);
      int roll;
      int t_app, t_ins, t_pop, t_del, t_srch, t_read;
      roll = $urandom_range(99);
      case (mode)
         MIX_GROW: begin
            t_app = 45; t_ins = 70; t_pop = 75; t_del = 80; t_srch = 90; t_read = 98;
         end
         MIX_SHRINK: begin
            t_app = 5; t_ins = 10; t_pop = 45; t_del = 75; t_srch = 87; t_read = 99;
         end
         default: begin
            t_app = 20; t_ins = 35; t_pop = 47; t_del = 62; t_srch = 80; t_read = 98;
         end
      endcase
      if (roll < t_app) return olst_pkg::ACT_APPEND;
      if (roll < t_ins) return olst_pkg::ACT_INSERT;
      if (roll < t_pop) return olst_pkg::ACT_POP;
      if (roll < t_del) return olst_pkg::ACT_DELETE;
      if (roll < t_srch) return olst_pkg::ACT_SEARCH;
      if (roll < t_read) return olst_pkg::ACT_READ;
      return $urandom_range(1) ? ACT_UNDEF_LO : ACT_UNDEF_HI;
   endfunction

   task automatic random_request(output req_beat_type rq);
      if (mix_left == 0) begin
         case (mix_mode)
            MIX_GROW:     mix_mode = MIX_BALANCED;
            MIX_BALANCED: mix_mode = MIX_SHRINK;
            default:      mix_mode = MIX_GROW;
         endcase
         mix_left = (mix_mode == MIX_BALANCED) ? $urandom_range(40, 100)
                                               : $urandom_range(100, 160);
      end
      mix_left--;
      rq.action = pick_action(mix_mode);

      // Mostly a useful index, sometimes anything the field can hold.
      if ($urandom_range(99) < 15) begin
         rq.position = olst_pkg::POS_WIDTH'($urandom_range(127));
      end else if (rq.action == olst_pkg::ACT_INSERT) begin
         rq.position = olst_pkg::POS_WIDTH'($urandom_range(list_count));
      end else if ((rq.action == olst_pkg::ACT_DELETE || rq.action == olst_pkg::ACT_READ) &&
                   list_count > 0) begin
         rq.position = olst_pkg::POS_WIDTH'($urandom_range(list_count - 1));
      end else begin
         rq.position = olst_pkg::POS_WIDTH'($urandom_range(127));
      end

      // A search often looks for a stored word; other words come from a small pool,
      // the extremes, or anywhere.
      if (rq.action == olst_pkg::ACT_SEARCH && list_count > 0 && $urandom_range(1) == 1) begin
         rq.value = list_words[$urandom_range(list_count - 1)];
      end else begin
         case ($urandom_range(9))
            0, 1: rq.value = int'($urandom_range(8)) - 4;
            2: begin
               case ($urandom_range(3))
                  0: rq.value = WORD_MIN;
                  1: rq.value = WORD_MAX;
                  2: rq.value = 0;
                  default: rq.value = -1;
               endcase
            end
            default: rq.value = $urandom;
         endcase
      end
   endtask

   // Request driver: bursts of beats with random gaps. The predictor runs on each beat
   // as it is accepted, so the next random beat sees the true list length.
   int           total_items;
   int           issued_count = 0;
   int           accepted_count = 0;
   int           burst_left = 0;
   int           gap_left = 0;
   bit           stim_done = 1'b0;
   req_beat_type held_req;
   bit           held_has_result;
   rsp_beat_type held_result;
   req_beat_type next_req;
   rsp_beat_type predicted;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         total_items = script.size() + RANDOM_ITEMS;
      end else begin
         if (req_valid && !req_stall) begin
            apply_list_request(held_req, predicted);
            pending_results.push_back(held_has_result ? held_result : predicted);
            accepted_count++;
            if (accepted_count == total_items) stim_done = 1'b1;
         end
         if (!req_valid || !req_stall) begin
            if (issued_count == total_items) begin
               req_valid <= 1'b0;
            end else if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else begin
               if (issued_count < script.size()) begin
                  held_req = script[issued_count].beat;
                  held_has_result = script[issued_count].has_result;
                  held_result = script[issued_count].result;
               end else begin
                  random_request(next_req);
                  held_req = next_req;
                  held_has_result = 1'b0;
               end
               issued_count++;
               req_valid <= 1'b1;
               req_action <= held_req.action;
               req_position <= held_req.position;
               req_value <= held_req.value;
               // Close the burst now and then, with an occasional long unbroken run.
               if (burst_left <= 1) begin
                  burst_left = ($urandom_range(7) == 0) ? $urandom_range(40, 80)
                                                        : $urandom_range(1, 12);
                  gap_left = $urandom_range(12);
               end else begin
                  burst_left--;
               end
            end
         end
      end
   end

   // Result receiver: the stall pattern changes mode at random.
   stall_kind_type stall_mode = STALL_NONE;
   int stall_mode_left = 0;
   int stall_phase = 0;
   int stall_period = 4;
   int stall_duty = 1;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_mode_left == 0) begin
            stall_mode = stall_kind_type'($urandom_range(3));
            stall_mode_left = $urandom_range(64, 256);
            stall_period = $urandom_range(2, 9);
            stall_duty = $urandom_range(1, stall_period - 1);
         end
         stall_mode_left--;
         stall_phase++;
         case (stall_mode)
            STALL_LIGHT:    rsp_stall <= ($urandom_range(99) < 25);
            STALL_HEAVY:    rsp_stall <= ($urandom_range(99) < 70);
            STALL_PERIODIC: rsp_stall <= ((stall_phase % stall_period) < stall_duty);
            default:        rsp_stall <= 1'b0;
         endcase
      end
   end

   // Result checker: each accepted beat against the oldest predicted result.
   rsp_beat_type want;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result beat: status %0d count %0d", $time,
                     rsp_status, rsp_entry_count);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d, got %0d", $time, want.status, rsp_status);
               fail_count++;
            end
            if (rsp_read_value !== want.read_value) begin
               $display("%0t: read_value expected %0d, got %0d", $time, want.read_value,
                        rsp_read_value);
               fail_count++;
            end
            if (rsp_found !== want.found) begin
               $display("%0t: found expected %0b, got %0b", $time, want.found, rsp_found);
               fail_count++;
            end
            if (rsp_entry_count !== want.entry_count) begin
               $display("%0t: entry_count expected %0d, got %0d", $time, want.entry_count,
                        rsp_entry_count);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: too long without any beat on either channel ends the run.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("ordered_list_store regression: fail");
      $finish;
   end

   // Reset once, then wait for all beats to go through and the block to settle.
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("ordered_list_store regression: pass");
      end else begin
         $display("ordered_list_store regression: fail");
      end
      $finish;
   end

endmodule
